// File: sv/ldp_pkg.sv
package ldp_pkg;

  // Configuration register widths.
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_MASK_W = 24;
  localparam int CFG_DATA_W = 24;

  // The divisor is either the image width or the power of two just above it.
  localparam int DIV_W = 14;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_HEIGHT = 2'd0;
  localparam cfg_index_t CFG_WIDTH  = 2'd1;
  localparam cfg_index_t CFG_MASK   = 2'd2;
  localparam cfg_index_t CFG_MODE   = 2'd3;

  localparam logic [1:0] PH_DONE  = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_FINAL = 2'd2;

  typedef struct packed {
    logic running;
    logic final_due;
  } seq_status_t;

  // Number of significant bits of a dimension.
  function automatic logic [3:0] bit_length(input logic [CFG_DIM_W-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < CFG_DIM_W; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

// File: sv/ldp_if.sv
interface ldp_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface ldp_pixel_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] row;
  logic [COORD_BITS-1:0] column;
  logic                  copy_pixel;
  logic                  last;

  modport source (output valid, output row, output column, output copy_pixel,
                  output last, input ready);
  modport sink (input valid, input row, input column, input copy_pixel,
                input last, output ready);
endinterface

// File: sv/ldp_sequencer.sv
module ldp_sequencer #(
  parameter int REG_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic                    restart,
  input  logic [REG_BITS-1:0]     mask,
  output logic [REG_BITS-1:0]     element,
  output ldp_pkg::seq_status_t    status
);
  import ldp_pkg::*;

  logic [REG_BITS-1:0] elem;
  logic [1:0]          phase;
  logic [REG_BITS-1:0] elem_eff;
  logic [1:0]          phase_eff;
  logic [REG_BITS-1:0] elem_next;

  // A restart reloads the register before the tick is evaluated.
  assign elem_eff  = restart ? REG_BITS'(1) : elem;
  assign phase_eff = restart ? PH_RUN : phase;

  assign elem_next = elem_eff[0] ? ((elem_eff >> 1) ^ mask) : (elem_eff >> 1);

  assign element          = elem_eff;
  assign status.running   = (phase_eff == PH_RUN);
  assign status.final_due = (phase_eff == PH_FINAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      elem  <= REG_BITS'(1);
      phase <= PH_DONE;
    end else if (step) begin
      unique case (phase_eff)
        PH_RUN: begin
          elem  <= elem_next;
          phase <= (elem_next == REG_BITS'(1)) ? PH_FINAL : PH_RUN;
        end
        PH_FINAL: begin
          elem  <= elem_eff;
          phase <= PH_DONE;
        end
        default: begin
          elem  <= elem_eff;
          phase <= phase_eff;
        end
      endcase
    end
  end

endmodule

// File: sv/ldp_divider.sv
module ldp_divider #(
  parameter int REG_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [REG_BITS-1:0]       dividend,
  input  logic [ldp_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [REG_BITS-1:0]       quotient,
  output logic [ldp_pkg::DIV_W-1:0] remainder
);
  import ldp_pkg::*;

  localparam int CNT_W = $clog2(REG_BITS);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [REG_BITS-1:0] quo;
  logic [DIV_W-1:0]    rem;
  logic [DIV_W-1:0]    dvs;
  logic [DIV_W:0]      partial;
  logic                fits;

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  assign partial = {rem, quo[REG_BITS-1]};
  assign fits    = (partial >= {1'b0, dvs});

  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= '0;
    end else if (busy) begin
      count <= count + CNT_W'(1);
      if (count == CNT_W'(REG_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[REG_BITS-2:0], fits};
      rem <= fits ? DIV_W'(partial - {1'b0, dvs}) : DIV_W'(partial);
    end
  end

endmodule

// File: sv/lfsr_dissolve_pixel_order.sv
// Pixel-dissolve address generator: every accepted tick yields one pixel
// coordinate from a right-shift Galois LFSR of REG_BITS bits. While the
// sequence runs, the element is split into row and column by a bit-serial
// restoring divider (by the image width in mode 0, by the power of two just
// above the width in mode 1), which retires one quotient bit per cycle.
// Ticks outside the running sequence, the final (0,0) pixel and mode 0 with
// a zero width skip the divider. In every case the next tick is taken only
// once the result of the last one has left the divider or hold state. The
// result sits in an output register, so a new tick is accepted while it
// waits to be taken. The feedback mask must be loaded by software; the user
// must write configuration only while the block is idle, as the block
// itself does not enforce it.
module lfsr_dissolve_pixel_order #(
  parameter int REG_BITS   = 24,
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  ldp_pkg::cfg_index_t            cfg_index,
  input  logic [ldp_pkg::CFG_DATA_W-1:0] cfg_data,
  ldp_tick_if.sink                       tick,
  ldp_pixel_if.source                    pixel
);
  import ldp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  localparam int CMP_W = (REG_BITS > CFG_DIM_W) ? REG_BITS : CFG_DIM_W;

  logic [CFG_DIM_W-1:0]  image_height;
  logic [CFG_DIM_W-1:0]  image_width;
  logic [CFG_MASK_W-1:0] feedback_mask;
  logic                  mode;

  logic [1:0] state;
  logic       accept;

  logic [REG_BITS-1:0] element;
  seq_status_t         seq_status;

  logic                  div_start;
  logic                  div_done;
  logic [DIV_W-1:0]      divisor;
  logic [REG_BITS-1:0]   quotient;
  logic [DIV_W-1:0]      remainder;
  logic                  row_fits;
  logic                  col_fits;

  logic [COORD_BITS-1:0] res_row;
  logic [COORD_BITS-1:0] res_col;
  logic                  res_copy;
  logic                  res_last;

  logic                  out_valid;
  logic [COORD_BITS-1:0] out_row;
  logic [COORD_BITS-1:0] out_col;
  logic                  out_copy;
  logic                  out_last;
  logic                  slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_height  <= CFG_DIM_W'(1);
      image_width   <= CFG_DIM_W'(1);
      feedback_mask <= '0;
      mode          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEIGHT: image_height  <= cfg_data[CFG_DIM_W-1:0];
        CFG_WIDTH:  image_width   <= cfg_data[CFG_DIM_W-1:0];
        CFG_MASK:   feedback_mask <= cfg_data[CFG_MASK_W-1:0];
        CFG_MODE:   mode          <= cfg_data[0];
      endcase
    end
  end

  assign tick.ready = (state == ST_IDLE);
  assign accept     = tick.valid && tick.ready;

  ldp_sequencer #(
    .REG_BITS (REG_BITS)
  ) u_sequencer (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .restart (tick.restart),
    .mask    (REG_BITS'(feedback_mask)),
    .element (element),
    .status  (seq_status)
  );

  // Mode 1 splits at the bit length of the width, which is a division by
  // the power of two just above it.
  assign divisor = mode ? (DIV_W'(1) << bit_length(image_width))
                        : DIV_W'(image_width);

  assign div_start = accept && seq_status.running
                     && !(!mode && (image_width == '0));

  ldp_divider #(
    .REG_BITS (REG_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (element),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign row_fits = (CMP_W'(quotient) < CMP_W'(image_height));
  assign col_fits = (remainder < {1'b0, image_width});

  assign slot_free = !out_valid || pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) state <= div_start ? ST_DIV : ST_HOLD;
        ST_DIV:  if (div_done) state <= ST_HOLD;
        ST_HOLD: if (slot_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      priority if (seq_status.running) begin
        // Zero width in mode 0: quotient all ones, remainder the element.
        res_row  <= '1;
        res_col  <= COORD_BITS'(element);
        res_copy <= 1'b0;
        res_last <= 1'b0;
      end else if (seq_status.final_due) begin
        res_row  <= '0;
        res_col  <= '0;
        res_copy <= 1'b1;
        res_last <= 1'b1;
      end else begin
        res_row  <= '0;
        res_col  <= '0;
        res_copy <= 1'b0;
        res_last <= 1'b0;
      end
    end else if (state == ST_DIV && div_done) begin
      res_row  <= COORD_BITS'(quotient);
      res_col  <= COORD_BITS'(remainder);
      res_copy <= mode ? (row_fits && col_fits) : row_fits;
      res_last <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && slot_free) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && slot_free) begin
      out_row  <= res_row;
      out_col  <= res_col;
      out_copy <= res_copy;
      out_last <= res_last;
    end
  end

  assign pixel.valid      = out_valid;
  assign pixel.row        = out_row;
  assign pixel.column     = out_col;
  assign pixel.copy_pixel = out_copy;
  assign pixel.last       = out_last;

endmodule
